@@ rtl/lwfd_pkg.sv @@
// shared constants for the white fade / dither block
// no dependencies
package lwfd_pkg;

  localparam int unsigned ELAPSED_W = 19;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned DIVISOR_W = MS_W + 10;
  localparam int unsigned ERR_W     = 10;

  localparam logic [31:0] MAX_ELAPSED_US = 32'd500000;
  localparam logic [9:0]  MS_TO_US       = 10'd1000;
  localparam logic [16:0] Q88_FULL       = 17'd65280;

  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_RGB   = 2'd1;
  localparam logic [1:0] MODE_WHITE = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_TRANSITION   = 2'd1;
  localparam logic [1:0] REG_DITHER       = 2'd2;
  localparam logic [1:0] REG_INTERLOCK    = 2'd3;

endpackage

@@ rtl/led_white_fade_dither.sv @@
// top level: linear cold/warm white fade with temporal dithering
// depends on lwfd_pkg and lwfd_div
//
// usage
//   config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
//   ready; write only while no request is in flight
//   a refresh request enters on in_valid_i/in_ready_o with a timestamp, two
//   white targets and a color mode; one result leaves on out_valid_o/out_ready_i
//   in_ready_o is high only while the sequencer is idle
//   a throttled request gets its result in the prep step; otherwise each
//   channel that still moves passes through the shared bit-serial divider
//   (elapsed * delta / transition) before the result is registered
//   the next request is taken at the earliest in the cycle after the result is
//   registered, so no new request is taken while one is in flight
//   the result sits in an output register; if the receiver stalls, the
//   sequencer waits in its output step and takes no new request
//   reset clears config registers, levels, held targets, fade deltas and dither errors
module led_white_fade_dither #(
  parameter int unsigned LEVEL_FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   now_us_i,
  input  logic [LEVEL_FRACTION_BITS:0]  target_cold_i,
  input  logic [LEVEL_FRACTION_BITS:0]  target_warm_i,
  input  logic [1:0]                    mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          throttled_o,
  output logic [7:0]                    cold_level_o,
  output logic [7:0]                    warm_level_o,
  output logic                          rgb_blank_o,
  output logic                          fading_o
);
  import lwfd_pkg::*;

  localparam int unsigned LFB = LEVEL_FRACTION_BITS;
  localparam int unsigned LW  = LFB + 1;          // level width
  localparam int unsigned DLW = LW + 1;           // signed delta width
  localparam int unsigned PW  = LW + ELAPSED_W;   // product / quotient width
  localparam int unsigned NW  = PW + 2;           // signed next-level width
  localparam int unsigned BW  = LW + 8;           // level * 255
  localparam int unsigned THR = (2 ** LFB) / 1000;
  localparam logic [LW-1:0] FULL = {1'b1, {LFB{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ADV, S_MUL, S_DIVGO, S_DIVW, S_FIN
  } state_e;

  state_e state_q;
  logic   ch_q;

  // configuration
  logic [31:0]   min_int_q;
  logic [MS_W-1:0] trans_q;
  logic          dith_q, intl_q;

  // request capture
  logic [31:0]   now_q;
  logic [LW-1:0] tgt_q [2];
  logic [1:0]    mode_q;

  // fade state
  logic [31:0]          last_q;
  logic [LW-1:0]        held_q [2];
  logic [LW-1:0]        level_q [2];
  logic signed [DLW-1:0] delta_q [2];
  logic signed [ERR_W-1:0] err_q [2];
  logic [ELAPSED_W-1:0] elap_q;
  logic                 clr_q;
  logic [PW-1:0]        prod_q;

  // output register
  logic       out_valid_q, thr_o_q, clr_o_q, fad_o_q;
  logic [7:0] cold_o_q, warm_o_q;

  // request prep
  logic [31:0]           elapsed;
  logic                  too_soon;
  logic [LW-1:0]         t_p [2], lvl_p [2], hld_p [2];
  logic signed [DLW-1:0] dlt_p [2];
  logic                  clr_p;

  always_comb begin
    elapsed  = now_q - last_q;
    too_soon = (min_int_q != '0) && (elapsed < min_int_q);
    clr_p    = 1'b0;
    for (int i = 0; i < 2; i++) begin
      t_p[i]   = (tgt_q[i] > FULL) ? FULL : tgt_q[i];
      lvl_p[i] = level_q[i];
      dlt_p[i] = delta_q[i];
      hld_p[i] = held_q[i];
    end
    if (intl_q) begin
      if (mode_q == MODE_WHITE) begin
        clr_p = 1'b1;
      end else if (mode_q == MODE_RGB) begin
        for (int i = 0; i < 2; i++) begin
          t_p[i]   = '0;
          lvl_p[i] = '0;
          dlt_p[i] = '0;
        end
      end
    end
    // a changed target restarts the fade from the present level, or jumps to it when the transition is zero
    if (held_q[0] != t_p[0] || held_q[1] != t_p[1]) begin
      for (int i = 0; i < 2; i++) begin
        hld_p[i] = t_p[i];
        if (trans_q == '0) begin
          lvl_p[i] = t_p[i];
          dlt_p[i] = '0;
        end else begin
          dlt_p[i] = $signed({1'b0, t_p[i]}) - $signed({1'b0, lvl_p[i]});
        end
      end
    end
  end

  // per-channel advance through the shared divider
  logic [LW-1:0]         cur_lvl, cur_hld;
  logic signed [DLW-1:0] cur_dlt;
  logic [DLW-1:0]        mag_w;
  logic [LW-1:0]         mag;
  logic                  div_start, div_done;
  logic [PW-1:0]         quot;

  assign cur_lvl = level_q[ch_q];
  assign cur_hld = held_q[ch_q];
  assign cur_dlt = delta_q[ch_q];
  assign mag_w   = cur_dlt[DLW-1] ? DLW'(-cur_dlt) : DLW'(cur_dlt);
  assign mag     = mag_w[LW-1:0];
  assign div_start = (state_q == S_DIVGO);

  lwfd_div #(
    .DW(PW),
    .VW(DIVISOR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (DIVISOR_W'(trans_q) * DIVISOR_W'(MS_TO_US)),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  logic signed [NW-1:0] lvl_ext, hld_ext, q_ext, nxt;
  logic                 snap;
  logic [LW-1:0]        adv_lvl;

  always_comb begin
    lvl_ext = $signed({{(NW-LW){1'b0}}, cur_lvl});
    hld_ext = $signed({{(NW-LW){1'b0}}, cur_hld});
    q_ext   = $signed({2'b00, quot});
    nxt     = cur_dlt[DLW-1] ? (lvl_ext - q_ext) : (lvl_ext + q_ext);
    snap    = (cur_dlt > 0 && nxt >= hld_ext) || (cur_dlt < 0 && nxt <= hld_ext);
    if (snap) begin
      adv_lvl = cur_hld;
    end else if (nxt < 0) begin
      adv_lvl = '0;
    end else if (nxt > $signed({{(NW-LW){1'b0}}, FULL})) begin
      adv_lvl = FULL;
    end else begin
      adv_lvl = nxt[LW-1:0];
    end
  end

  // byte conversion, both channels side by side
  logic [LW-1:0]         dif [2];
  logic                  fading;
  logic [7:0]            byte_p [2], byte_d [2];
  logic signed [ERR_W-1:0] err_n [2];
  logic [BW-1:0]         scaled [2];
  logic [BW-1:0]         rounded [2];
  logic [16:0]           base [2];
  logic signed [18:0]    desired [2];
  logic signed [18:0]    rnd [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dif[i]     = (level_q[i] > held_q[i]) ? (level_q[i] - held_q[i])
                                            : (held_q[i] - level_q[i]);
      scaled[i]  = BW'(level_q[i]) * BW'(255);
      rounded[i] = (scaled[i] + BW'(FULL >> 1)) >> LFB;
      byte_p[i]  = (rounded[i] > BW'(255)) ? 8'd255 : rounded[i][7:0];
      base[i]    = 17'(scaled[i] >> (LFB - 8));
      desired[i] = $signed({2'b00, base[i]}) + 19'(err_q[i]);
      rnd[i]     = (desired[i] + 19'sd128) >>> 8;
      if (desired[i] >= $signed({2'b00, Q88_FULL})) begin
        byte_d[i] = 8'd255;
      end else if (desired[i] <= 0) begin
        byte_d[i] = 8'd0;
      end else begin
        byte_d[i] = rnd[i][7:0];
      end
      if (base[i] == '0 || base[i] >= Q88_FULL) begin
        err_n[i] = '0;
      end else begin
        err_n[i] = ERR_W'(desired[i] - $signed({3'b000, byte_d[i], 8'h00}));
      end
    end
    fading = (dif[0] > LW'(THR)) || (dif[1] > LW'(THR));
  end

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_q || out_ready_i;
  // output register takes a new result in the throttle step or the final step
  assign out_load = out_free && ((state_q == S_PREP && too_soon) || state_q == S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      min_int_q   <= '0;
      trans_q     <= '0;
      dith_q      <= 1'b0;
      intl_q      <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        held_q[i]  <= '0;
        level_q[i] <= '0;
        delta_q[i] <= '0;
        err_q[i]   <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MIN_INTERVAL: min_int_q <= cfg_data_i;
          REG_TRANSITION:   trans_q   <= cfg_data_i[MS_W-1:0];
          REG_DITHER:       dith_q    <= cfg_data_i[0];
          REG_INTERLOCK:    intl_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (too_soon) begin
            // throttled request: fade state and dither errors stay unchanged
            if (out_free) begin
              thr_o_q     <= 1'b1;
              cold_o_q    <= '0;
              warm_o_q    <= '0;
              clr_o_q     <= 1'b0;
              fad_o_q     <= 1'b0;
              state_q     <= S_IDLE;
            end
          end else begin
            last_q <= now_q;
            elap_q <= (elapsed > MAX_ELAPSED_US) ? '0 : elapsed[ELAPSED_W-1:0];
            clr_q  <= clr_p;
            for (int i = 0; i < 2; i++) begin
              held_q[i]  <= hld_p[i];
              level_q[i] <= lvl_p[i];
              delta_q[i] <= dlt_p[i];
            end
            ch_q    <= 1'b0;
            state_q <= S_ADV;
          end
        end
        S_ADV: begin
          if (cur_lvl == cur_hld || trans_q == '0) begin
            level_q[ch_q] <= cur_hld;
            ch_q          <= 1'b1;
            state_q       <= ch_q ? S_FIN : S_ADV;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= PW'(mag) * PW'(elap_q);
          state_q <= S_DIVGO;
        end
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            level_q[ch_q] <= adv_lvl;
            ch_q          <= 1'b1;
            state_q       <= ch_q ? S_FIN : S_ADV;
          end
        end
        S_FIN: begin
          if (out_free) begin
            thr_o_q     <= 1'b0;
            clr_o_q     <= clr_q;
            fad_o_q     <= fading;
            if (dith_q && fading) begin
              cold_o_q <= byte_d[0];
              warm_o_q <= byte_d[1];
              err_q[0] <= err_n[0];
              err_q[1] <= err_n[1];
            end else begin
              cold_o_q <= byte_p[0];
              warm_o_q <= byte_p[1];
              err_q[0] <= '0;
              err_q[1] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q    <= now_us_i;
      tgt_q[0] <= target_cold_i;
      tgt_q[1] <= target_warm_i;
      mode_q   <= mode_i;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign throttled_o  = thr_o_q;
  assign cold_level_o = cold_o_q;
  assign warm_level_o = warm_o_q;
  assign rgb_blank_o  = clr_o_q;
  assign fading_o     = fad_o_q;

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q[0] <= FULL && level_q[1] <= FULL)
    else $error("level above full scale");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> trans_q != '0)
    else $error("divider started with zero transition");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q[0] <= FULL && held_q[1] <= FULL)
    else $error("held target above full scale");
`endif

endmodule

@@ rtl/lwfd_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module lwfd_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [VW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? VW'(rem_sh - {1'b0, div_q}) : rem_sh[VW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ dv/testbench.sv @@
// testbench for led_white_fade_dither: fade, throttle, interlock and dither checks
// depends on lwfd_pkg and the rtl top level; predicts each result in a scoreboard class
`timescale 1ns / 1ps

module testbench;
  import lwfd_pkg::*;

  localparam int unsigned LFB = 16;
  localparam longint FULL = longint'(1) << LFB;
  localparam longint FADE_THR = FULL / 1000;
  localparam longint Q88_MAX = 255 * 256;

  typedef struct packed {
    logic       throttled;
    logic [7:0] cold;
    logic [7:0] warm;
    logic       rgb_blank;
    logic       fading;
  } refresh_result_t;

  // fade predictor plus store of expected results
  class fade_scoreboard;
    bit [31:0] min_interval_us;
    bit [15:0] transition_ms;
    bit        dither_on;
    bit        interlock_on;
    bit [31:0] last_refresh_us;
    longint    held_cold, held_warm, lvl_cold, lvl_warm, delta_cold, delta_warm;
    longint    err_cold, err_warm;
    refresh_result_t pending[$];
    int        mismatches;

    function void write_reg(logic [1:0] idx, bit [31:0] data);
      case (idx)
        REG_MIN_INTERVAL: min_interval_us = data;
        REG_TRANSITION:   transition_ms = data[15:0];
        REG_DITHER:       dither_on = data[0];
        REG_INTERLOCK:    interlock_on = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp_full(bit [16:0] raw);
      return (longint'(raw) > FULL) ? FULL : longint'(raw);
    endfunction

    function longint step_level(longint lvl, longint held, longint dlt, longint el);
      longint mag, mv, nxt;
      if (lvl == held) return lvl;
      if (transition_ms == 0) return held;
      mag = dlt < 0 ? -dlt : dlt;
      mv = (mag * el) / (longint'(transition_ms) * 1000);
      if (dlt < 0) mv = -mv;
      nxt = lvl + mv;
      if ((dlt > 0 && nxt >= held) || (dlt < 0 && nxt <= held)) return held;
      if (nxt < 0) nxt = 0;
      if (nxt > FULL) nxt = FULL;
      return nxt;
    endfunction

    function bit [7:0] round_byte(longint lvl);
      longint v;
      v = (lvl * 255 + (FULL >> 1)) >>> LFB;
      return v > 255 ? 8'd255 : v[7:0];
    endfunction

    function bit [7:0] dither_out(longint lvl, ref longint err);
      longint base, want, v;
      base = (lvl * 255) >>> (LFB - 8);
      want = base + err;
      if (want >= Q88_MAX) v = 255;
      else if (want <= 0) v = 0;
      else v = (want + 128) >>> 8;
      err = (base <= 0 || base >= Q88_MAX) ? 0 : want - v * 256;
      return v[7:0];
    endfunction

    function void note_request(bit [31:0] now, bit [16:0] tc_raw, bit [16:0] tw_raw,
                               bit [1:0] mode);
      refresh_result_t r;
      longint tc, tw, dc, dw;
      bit [31:0] el;
      r = '0;
      tc = clamp_full(tc_raw);
      tw = clamp_full(tw_raw);
      el = now - last_refresh_us;
      if (min_interval_us != 0 && el < min_interval_us) begin
        r.throttled = 1'b1;
        pending.push_back(r);
        return;
      end
      last_refresh_us = now;
      if (el > MAX_ELAPSED_US) el = 0;
      if (interlock_on) begin
        if (mode == MODE_WHITE) begin
          r.rgb_blank = 1'b1;
        end else if (mode == MODE_RGB) begin
          tc = 0; tw = 0; lvl_cold = 0; lvl_warm = 0; delta_cold = 0; delta_warm = 0;
        end
      end
      if (held_cold != tc || held_warm != tw) begin
        held_cold = tc;
        held_warm = tw;
        if (transition_ms == 0) begin
          lvl_cold = tc; lvl_warm = tw; delta_cold = 0; delta_warm = 0;
        end else begin
          delta_cold = tc - lvl_cold;
          delta_warm = tw - lvl_warm;
        end
      end
      lvl_cold = step_level(lvl_cold, held_cold, delta_cold, longint'(el));
      lvl_warm = step_level(lvl_warm, held_warm, delta_warm, longint'(el));
      dc = lvl_cold - tc; if (dc < 0) dc = -dc;
      dw = lvl_warm - tw; if (dw < 0) dw = -dw;
      r.fading = (dc > FADE_THR) || (dw > FADE_THR);
      if (dither_on && r.fading) begin
        r.cold = dither_out(lvl_cold, err_cold);
        r.warm = dither_out(lvl_warm, err_warm);
      end else begin
        r.cold = round_byte(lvl_cold);
        r.warm = round_byte(lvl_warm);
        err_cold = 0;
        err_warm = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(refresh_result_t got);
      refresh_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.throttled !== exp.throttled || got.cold !== exp.cold ||
          got.warm !== exp.warm || got.rgb_blank !== exp.rgb_blank ||
          got.fading !== exp.fading) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] now_us_i = '0;
  logic [16:0] target_cold_i = '0;
  logic [16:0] target_warm_i = '0;
  logic [1:0]  mode_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        throttled_o, rgb_blank_o, fading_o;
  logic [7:0]  cold_level_o, warm_level_o;

  fade_scoreboard sb = new();
  bit  idle_on = 1'b1;       // random gaps allowed on both sides
  bit  hold_off = 1'b0;      // long receiver stall in progress
  bit  pressure_done = 1'b0; // long stall has been started
  bit [31:0] clock_us = '0;  // running timestamp for requests
  int  stall_left = 0;       // remaining cycles of a receiver stall burst

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  led_white_fade_dither #(.LEVEL_FRACTION_BITS(LFB)) uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .now_us_i, .target_cold_i, .target_warm_i, .mode_i,
    .out_valid_o, .out_ready_i, .throttled_o, .cold_level_o, .warm_level_o,
    .rgb_blank_o, .fading_o
  );

  // write one register, only while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one request, with an optional random gap in front
  task automatic send_request(bit [31:0] now, bit [16:0] tc, bit [16:0] tw, bit [1:0] mode);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    now_us_i      <= now;
    target_cold_i <= tc;
    target_warm_i <= tw;
    mode_i        <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(now, tc, tw, mode);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain every expected result, then let the block settle before a register write
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  // mostly small steps of a fade, sometimes long gaps or wraps
  function automatic bit [31:0] next_time();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return clock_us + $urandom_range(0, 50);
      2: return clock_us + 32'd500000 + $urandom_range(0, 2);
      default: return clock_us + $urandom_range(100, 40000);
    endcase
  endfunction

  function automatic bit [16:0] pick_target();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF - $urandom_range(0, 65534); // above full, clamped
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // receiver: random stall bursts, plus one long hold-off driven elsewhere
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result monitor, sampled at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{throttled_o, cold_level_o, warm_level_o, rgb_blank_o, fading_o});
    end
  end

  // long receiver hold-off early in the random part
  initial begin
    wait (pressure_done);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // overall time limit for the whole run
  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit [31:0] t;
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: jumps with transition zero, extremes of fields, all modes
    write_reg(REG_INTERLOCK, 32'd1);
    send_request(32'd10, 17'd65536, 17'd0, MODE_WHITE);
    send_request(32'd20, 17'h1FFFF, 17'd65536, MODE_RGB);
    send_request(32'd30, 17'd12345, 17'd54321, MODE_OTHER);
    send_request(32'd40, 17'd32768, 17'd1, MODE_SPARE);
    send_request(32'd600000, 17'd0, 17'h10001, MODE_WHITE);
    wait_idle();
    write_reg(REG_TRANSITION, 32'hFFFF);
    write_reg(REG_DITHER, 32'd1);
    write_reg(REG_MIN_INTERVAL, 32'd1000);
    send_request(32'd601000, 17'd65536, 17'd0, MODE_WHITE);
    send_request(32'd601500, 17'd0, 17'd0, MODE_WHITE);        // throttled
    send_request(32'd700000, 17'd65536, 17'd0, MODE_OTHER);
    send_request(32'd1199999, 17'd65536, 17'd0, MODE_OTHER);    // gap near the limit
    send_request(32'd1700001, 17'd65536, 17'd0, MODE_OTHER);    // long gap counts zero
    send_request(32'hFFFF_FFF0, 17'd100, 17'd65536, MODE_WHITE);
    send_request(32'h0000_1000, 17'd100, 17'd65536, MODE_RGB); // wrap plus rgb clear
    wait_idle();
    write_reg(REG_TRANSITION, 32'd1);
    write_reg(REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    send_request(32'd5000, 17'd40000, 17'd20000, MODE_OTHER);
    send_request(32'd6000, 17'd0, 17'd0, MODE_OTHER);
    wait_idle();

    // random phases over several settings, extremes included
    clock_us = 32'd0;
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      write_reg(REG_MIN_INTERVAL, phase == 0 ? 32'd0 : (phase == 7 ? 32'hFFFF_FFFF :
                $urandom_range(0, 20000)));
      write_reg(REG_TRANSITION, phase == 1 ? 32'd0 : (phase == 2 ? 32'hFFFF :
                $urandom_range(1, 3000)));
      write_reg(REG_DITHER, $urandom_range(0, 1));
      write_reg(REG_INTERLOCK, $urandom_range(0, 1));
      if (phase == 6) idle_on = 1'b0;
      repeat (150) begin
        t = next_time();
        clock_us = t;
        send_request(t, pick_target(), pick_target(), $urandom_range(0, 3));
        if (phase == 1 && !pressure_done) begin
          pressure_done = 1'b1; // starts the long hold-off once
          clock_us = 32'hFFFF_FFFF;
          repeat (40) send_request(clock_us, pick_target(), pick_target(), MODE_WHITE);
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ led_white_fade_dither.f @@
rtl/lwfd_pkg.sv
rtl/lwfd_div.sv
rtl/led_white_fade_dither.sv
dv/testbench.sv
